// File: hdl/ucal_pkg.sv
// ----------------------------------------------------------------------------
// ucal_pkg
// Shared types, constants and small tables for the Unix time to local
// calendar pipeline.
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 6;

  localparam logic [CfgIndexW-1:0] REG_ZONE_CODE  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_DST_ENABLE = 2'd1;

  localparam logic [5:0] WestBase = 6'd20;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned DaysPerEra  = 146097;
  localparam int unsigned EpochShift  = 719468;
  localparam int unsigned SummerLastWeek = 25;

  // Exact quotient by reciprocal: floor(x / d) == (x * ceil(2^k / d)) >> k
  // holds whenever 2^k >= 2^(bits of x) * 2^(bits of d).
  localparam int unsigned DayK = 35;
  localparam longint unsigned DayM = ((64'd1 << DayK) + 675 - 1) / 675;
  localparam int unsigned HourK = 29;
  localparam longint unsigned HourM = ((64'd1 << HourK) + 3600 - 1) / 3600;
  localparam int unsigned MinK = 18;
  localparam longint unsigned MinM = ((64'd1 << MinK) + 60 - 1) / 60;
  localparam int unsigned WeekK = 20;
  localparam longint unsigned WeekM = ((64'd1 << WeekK) + 7 - 1) / 7;
  localparam int unsigned EraK = 38;
  localparam longint unsigned EraM = ((64'd1 << EraK) + DaysPerEra - 1) / DaysPerEra;
  localparam int unsigned QuadK = 29;
  localparam longint unsigned QuadM = ((64'd1 << QuadK) + 1460 - 1) / 1460;
  localparam int unsigned YearK = 27;
  localparam longint unsigned YearM = ((64'd1 << YearK) + 365 - 1) / 365;
  localparam int unsigned CentK = 16;
  localparam longint unsigned CentM = ((64'd1 << CentK) + 100 - 1) / 100;

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] secs;
  } day_word_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_word_t;

  // First day of each month in a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month lengths; February always counts 29 days here.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd2:    r = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd0:    r = 5'd31;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ucal_zone.sv
// ----------------------------------------------------------------------------
// ucal_zone
// Applies the whole-hour zone shift with saturation at both ends.
// ----------------------------------------------------------------------------
module ucal_zone
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_time,
  input  logic [5:0]  zone_code,
  output logic        out_valid,
  output logic [31:0] out_time
);

  logic [17:0] shift_secs;
  logic        west;
  logic [32:0] east_sum;
  logic [31:0] time_next;

  always_comb begin
    west = zone_code > WestBase;
    if (west) begin
      shift_secs = 18'(zone_code - WestBase) * 18'(SecsPerHour);
    end else begin
      shift_secs = 18'(zone_code) * 18'(SecsPerHour);
    end
    east_sum = 33'(in_time) + 33'(shift_secs);
    if (west) begin
      time_next = (in_time >= 32'(shift_secs)) ? in_time - 32'(shift_secs) : 32'd0;
    end else begin
      time_next = east_sum[32] ? 32'hFFFF_FFFF : east_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_time <= time_next;
  end

endmodule

// File: hdl/ucal_days.sv
// ----------------------------------------------------------------------------
// ucal_days
// Splits the shifted time into whole days and seconds of the day.
// ----------------------------------------------------------------------------
module ucal_days
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_time,
  output logic        out_valid,
  output day_word_t   out_word
);

  logic        prod_valid;
  logic [50:0] prod;
  logic [31:0] time_q;
  logic [15:0] days;

  assign days = 16'(prod >> DayK);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod          <= 51'(in_time[31:7]) * 51'(DayM);
    time_q        <= in_time;
    out_word.days <= days;
    out_word.secs <= 17'(time_q - 32'(days) * 32'(SecsPerDay));
  end

endmodule

// File: hdl/ucal_civil.sv
// ----------------------------------------------------------------------------
// ucal_civil
// Converts a day count and second of day into a Gregorian date, weekday
// and time of day over seven register stages.
// ----------------------------------------------------------------------------
module ucal_civil
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  day_word_t   in_word,
  output logic        out_valid,
  output civil_word_t out_word
);

  logic [6:0] valid;

  // Stage 1
  logic [19:0] z_comb;
  logic [16:0] wx_comb;
  logic [19:0] s1_z;
  logic [40:0] s1_era_prod;
  logic [16:0] s1_wx;
  logic [34:0] s1_wk_prod;
  logic [16:0] s1_secs;
  logic [34:0] s1_hr_prod;

  // Stage 2
  logic [2:0]  era_c;
  logic [13:0] wq_c;
  logic [4:0]  hour_c;
  logic [2:0]  s2_era;
  logic [17:0] s2_doe;
  logic [2:0]  s2_wday;
  logic [4:0]  s2_hour;
  logic [11:0] s2_rh;

  // Stage 3
  logic [36:0] s3_quad_prod;
  logic [1:0]  s3_cent4;
  logic        s3_last;
  logic [17:0] s3_doe;
  logic [2:0]  s3_era;
  logic [2:0]  s3_wday;
  logic [4:0]  s3_hour;
  logic [24:0] s3_min_prod;
  logic [11:0] s3_rh;

  // Stage 4
  logic [5:0]  minute_c;
  logic [17:0] s4_n;
  logic [17:0] s4_doe;
  logic [2:0]  s4_era;
  logic [2:0]  s4_wday;
  logic [4:0]  s4_hour;
  logic [5:0]  s4_minute;
  logic [5:0]  s4_second;

  // Stage 5
  logic [36:0] s5_yr_prod;
  logic [17:0] s5_doe;
  logic [2:0]  s5_era;
  logic [2:0]  s5_wday;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_minute;
  logic [5:0]  s5_second;

  // Stage 6
  logic [8:0]  yoe_c;
  logic [1:0]  cent_c;
  logic [17:0] yday_base_c;
  logic [8:0]  s6_doy;
  logic [11:0] s6_year;
  logic [2:0]  s6_wday;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_minute;
  logic [5:0]  s6_second;

  // Stage 7
  logic [3:0]  mp_c;
  logic [3:0]  month_c;

  assign z_comb  = 20'(in_word.days) + 20'(EpochShift);
  assign wx_comb = 17'(in_word.days) + 17'd4;

  assign era_c  = 3'(s1_era_prod >> EraK);
  assign wq_c   = 14'(s1_wk_prod >> WeekK);
  assign hour_c = 5'(s1_hr_prod >> HourK);

  assign minute_c = 6'(s3_min_prod >> MinK);

  assign yoe_c       = 9'(s5_yr_prod >> YearK);
  assign cent_c      = 2'((18'(yoe_c) * 18'(CentM)) >> CentK);
  assign yday_base_c = 18'(yoe_c) * 18'd365 + 18'(yoe_c[8:2]) - 18'(cent_c);

  always_comb begin
    mp_c = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s6_doy >= month_start(4'(k))) begin
        mp_c = 4'(k);
      end
    end
    month_c = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:0], in_valid};
    end
  end

  assign out_valid = valid[6];

  always_ff @(posedge clk) begin
    s1_z        <= z_comb;
    s1_era_prod <= 41'(z_comb) * 41'(EraM);
    s1_wx       <= wx_comb;
    s1_wk_prod  <= 35'(wx_comb) * 35'(WeekM);
    s1_secs     <= in_word.secs;
    s1_hr_prod  <= 35'(in_word.secs) * 35'(HourM);

    s2_era  <= era_c;
    s2_doe  <= 18'(s1_z - 20'(era_c) * 20'(DaysPerEra));
    s2_wday <= 3'(s1_wx - 17'(wq_c) * 17'd7);
    s2_hour <= hour_c;
    s2_rh   <= 12'(s1_secs - 17'(hour_c) * 17'(SecsPerHour));

    s3_quad_prod <= 37'(s2_doe) * 37'(QuadM);
    s3_cent4     <= 2'((s2_doe >= 18'd36524) ? 1 : 0) + 2'((s2_doe >= 18'd73048) ? 1 : 0)
                  + 2'((s2_doe >= 18'd109572) ? 1 : 0);
    s3_last      <= s2_doe == 18'(DaysPerEra - 1);
    s3_doe       <= s2_doe;
    s3_era       <= s2_era;
    s3_wday      <= s2_wday;
    s3_hour      <= s2_hour;
    s3_min_prod  <= 25'(s2_rh) * 25'(MinM);
    s3_rh        <= s2_rh;

    s4_n      <= s3_doe - 18'(s3_quad_prod >> QuadK) + 18'(s3_cent4) - 18'(s3_last);
    s4_doe    <= s3_doe;
    s4_era    <= s3_era;
    s4_wday   <= s3_wday;
    s4_hour   <= s3_hour;
    s4_minute <= minute_c;
    s4_second <= 6'(s3_rh - 12'(minute_c) * 12'd60);

    s5_yr_prod <= 37'(s4_n) * 37'(YearM);
    s5_doe     <= s4_doe;
    s5_era     <= s4_era;
    s5_wday    <= s4_wday;
    s5_hour    <= s4_hour;
    s5_minute  <= s4_minute;
    s5_second  <= s4_second;

    s6_doy    <= 9'(s5_doe - yday_base_c);
    s6_year   <= 12'(yoe_c) + 12'(s5_era) * 12'd400;
    s6_wday   <= s5_wday;
    s6_hour   <= s5_hour;
    s6_minute <= s5_minute;
    s6_second <= s5_second;

    out_word.year         <= s6_year + 12'((month_c <= 4'd2) ? 1 : 0);
    out_word.month        <= month_c;
    out_word.day_of_month <= 5'(s6_doy - month_start(mp_c) + 9'd1);
    out_word.weekday      <= s6_wday;
    out_word.hour         <= s6_hour;
    out_word.minute       <= s6_minute;
    out_word.second       <= s6_second;
  end

endmodule

// File: hdl/ucal_dst.sv
// ----------------------------------------------------------------------------
// ucal_dst
// Applies the European summer time rule and registers the result word.
// ----------------------------------------------------------------------------
module ucal_dst
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  civil_word_t in_word,
  input  logic        dst_enable,
  output logic        out_valid,
  output civil_word_t out_word,
  output logic        out_dst
);

  logic        late;
  logic        summer;
  civil_word_t word_next;

  always_comb begin
    late = (6'(in_word.day_of_month) >= 6'(in_word.weekday) + 6'(SummerLastWeek))
           && (in_word.weekday != 3'd0 || in_word.hour >= 5'd2);
    if (in_word.month < 4'd3 || in_word.month > 4'd10) begin
      summer = 1'b0;
    end else if (late && in_word.month == 4'd10) begin
      summer = 1'b0;
    end else if (!late && in_word.month == 4'd3) begin
      summer = 1'b0;
    end else begin
      summer = 1'b1;
    end
    summer = summer && dst_enable;

    word_next = in_word;
    if (summer) begin
      if (in_word.hour == 5'd23) begin
        word_next.hour    = 5'd0;
        word_next.weekday = (in_word.weekday == 3'd6) ? 3'd0 : in_word.weekday + 3'd1;
        if (in_word.day_of_month == month_len(in_word.month)) begin
          word_next.day_of_month = 5'd1;
          word_next.month        = in_word.month + 4'd1;
        end else begin
          word_next.day_of_month = in_word.day_of_month + 5'd1;
        end
      end else begin
        word_next.hour = in_word.hour + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
    out_dst  <= summer;
  end

endmodule

// File: hdl/unix_time_to_local_calendar_dst.sv
// ----------------------------------------------------------------------------
// unix_time_to_local_calendar_dst
// Converts Unix seconds to a local calendar date and time with a whole-hour
// zone offset and the European summer time rule.
//
//   Channel  Handshake             Word
//   input    start / busy          unix_seconds
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//   result   done (one cycle)      year .. dst_active
//
// A word may enter on every cycle while busy is low; its result appears on
// done after it passes the zone stage, two day-split stages, seven calendar
// stages and the summer time output stage. Items never wait on each other.
// Reset clears the pipeline valid bits and both registers and holds busy
// high through reset; busy clears at the first clock on which reset is low.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
module unix_time_to_local_calendar_dst
  import ucal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          unix_seconds,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output logic                 done,
  output logic [11:0]          year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month,
  output logic [2:0]           weekday,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second,
  output logic                 dst_active
);

  logic        zone_code_valid;
  logic [5:0]  zone_code;
  logic        dst_enable;
  logic        zone_valid;
  logic [31:0] zone_time;
  logic        days_valid;
  day_word_t   days_word;
  logic        civil_valid;
  civil_word_t civil_word;
  civil_word_t result_word;

  assign zone_code_valid = start && !busy;
  assign cfg_ready       = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      zone_code  <= 6'd0;
      dst_enable <= 1'b0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZONE_CODE:  zone_code  <= cfg_data[5:0];
          REG_DST_ENABLE: dst_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  ucal_zone u_zone (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (zone_code_valid),
    .in_time   (unix_seconds),
    .zone_code (zone_code),
    .out_valid (zone_valid),
    .out_time  (zone_time)
  );

  ucal_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (zone_valid),
    .in_time   (zone_time),
    .out_valid (days_valid),
    .out_word  (days_word)
  );

  ucal_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (days_valid),
    .in_word   (days_word),
    .out_valid (civil_valid),
    .out_word  (civil_word)
  );

  ucal_dst u_dst (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (civil_valid),
    .in_word    (civil_word),
    .dst_enable (dst_enable),
    .out_valid  (done),
    .out_word   (result_word),
    .out_dst    (dst_active)
  );

  assign year         = result_word.year;
  assign month        = result_word.month;
  assign day_of_month = result_word.day_of_month;
  assign weekday      = result_word.weekday;
  assign hour         = result_word.hour;
  assign minute       = result_word.minute;
  assign second       = result_word.second;

endmodule
